>>> hw/rtl/pcss_pkg.sv
// Shared constants, payload types and control structs of the periodic channel send scheduler.
package pcss_pkg;

	localparam int MAX_CHANNELS = 16;
	localparam int PERIOD_BITS  = 16;
	localparam int CH_W         = $clog2(MAX_CHANNELS);
	localparam int CNT_W        = $clog2(MAX_CHANNELS + 1);
	localparam int KIND_W       = 3;
	localparam int CHAN_FIELD_W = 4;
	localparam int REQ_PERIOD_W = 16;
	localparam int ACT_W        = 5;
	localparam int MINP_W       = 8;
	localparam int CFG_DATA_W   = 8;

	localparam logic [ACT_W-1:0]       ACTIVE_RESET = ACT_W'(16);
	localparam logic [MINP_W-1:0]      MINP_RESET   = MINP_W'(10);
	localparam logic [PERIOD_BITS-1:0] PERIOD_MAX   = '1;

	localparam logic [KIND_W-1:0] KIND_TICK       = 3'd0;
	localparam logic [KIND_W-1:0] KIND_UPDATE     = 3'd1;
	localparam logic [KIND_W-1:0] KIND_SET_PERIOD = 3'd2;
	localparam logic [KIND_W-1:0] KIND_STOP_ALL   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_WRITE_DONE = 3'd4;

	localparam logic CFG_ACTIVE_CHANNELS = 1'b0;
	localparam logic CFG_MIN_PERIOD      = 1'b1;

	typedef logic [PERIOD_BITS-1:0] period_t;

	typedef struct packed {
		logic [KIND_W-1:0]       kind;
		logic [CHAN_FIELD_W-1:0] channel;
		logic [REQ_PERIOD_W-1:0] period_ms;
	} req_t;

	typedef struct packed {
		logic                    grant_valid;
		logic [CHAN_FIELD_W-1:0] grant_channel;
		logic                    status;
	} rsp_t;

	typedef struct packed {
		logic load_item;
		logic exec;
		logic tick_step;
		logic mod_step;
		logic idx_clr;
		logic scan_step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              upd_hit;
		logic              n_zero;
		logic              idx_last;
		logic              ptr_ge_n;
		logic              no_scan;
		logic              scan_hit;
		logic              out_free;
	} sts_t;

	function automatic period_t sat_period(input logic [REQ_PERIOD_W-1:0] req);
		logic [31:0] r;
		r = 32'(req);
		if (r > 32'(PERIOD_MAX)) begin
			return PERIOD_MAX;
		end
		return PERIOD_BITS'(r);
	endfunction

endpackage

>>> hw/rtl/periodic_channel_send_scheduler_unit.sv
// Top level of the periodic channel send scheduler: controller, datapath and checks.
//
// Usage: commands arrive on the req channel (req_valid, req_stall, req) and every
// command yields exactly one transfer on the rsp channel (rsp_valid, rsp_stall, rsp)
// carrying grant_valid, grant_channel and status. A command is taken when req_valid
// is high and req_stall low; a response leaves when rsp_valid is high and rsp_stall low.
// Configuration writes (cfg_valid, cfg_index, cfg_data) are always ready and
// must be issued only while the block is idle.
// Set period, stop all, write done, unused kinds and an update that marks nothing
// pass from the decode state straight to the done state; an update that marks a
// channel pending goes on to fold the pointer below n and scan up to n channels.
// A tick walks the n active channels one per cycle through the single table port,
// then runs the same fold and scan. Fold and scan are skipped while a write is busy.
// One command is in work at a time: req_stall stays high from acceptance until the
// response is placed in the output register, which lets the next command enter
// while that response still waits.
// Reset: periods cleared, countdowns set to 1, no channel pending, no write busy.
// A stalled response holds in the output register and the block stops at the end
// of its next command until the register frees.
module periodic_channel_send_scheduler_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  pcss_pkg::req_t                  req,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output pcss_pkg::rsp_t                  rsp,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic                            cfg_index,
	input  logic [pcss_pkg::CFG_DATA_W-1:0] cfg_data
);

	pcss_pkg::cmd_t cmd;
	pcss_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	pcss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	pcss_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts)
	);

`ifndef NO_ASSERTIONS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("command accepted while previous command still in work");

	a_idle_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.grant_valid) |-> (rsp.grant_channel == '0))
		else $error("grant channel nonzero without a grant");

	a_error_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status) |-> !rsp.grant_valid)
		else $error("grant issued on an erroneous command");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!rsp_valid || !rsp_stall))
		else $error("output register overwritten while stalled");
`endif

endmodule

>>> hw/rtl/pcss_ctrl.sv
// Controller state machine of the periodic channel send scheduler.
module pcss_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  pcss_pkg::sts_t  sts,
	output pcss_pkg::cmd_t  cmd
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DECODE = 6'b000010,
		S_TICK   = 6'b000100,
		S_MOD    = 6'b001000,
		S_SCAN   = 6'b010000,
		S_DONE   = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		cmd       = '0;
		state_nx  = state_q;
		req_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.load_item = 1'b1;
					state_nx      = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.exec = 1'b1;
				unique case (sts.kind)
					pcss_pkg::KIND_TICK:   state_nx = sts.n_zero ? S_DONE : S_TICK;
					pcss_pkg::KIND_UPDATE: state_nx = sts.upd_hit ? S_MOD : S_DONE;
					default:               state_nx = S_DONE;
				endcase
			end
			S_TICK: begin
				cmd.tick_step = 1'b1;
				if (sts.idx_last) begin
					state_nx = S_MOD;
				end
			end
			S_MOD: begin
				if (sts.no_scan) begin
					state_nx = S_DONE;
				end else if (sts.ptr_ge_n) begin
					cmd.mod_step = 1'b1;
				end else begin
					cmd.idx_clr = 1'b1;
					state_nx    = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_hit || sts.idx_last) begin
					state_nx = S_DONE;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

endmodule

>>> hw/rtl/pcss_dp.sv
// Datapath of the periodic channel send scheduler: channel tables, scan pointer, result register.
module pcss_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pcss_pkg::req_t                      req,
	output pcss_pkg::rsp_t                      rsp,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	input  logic                                cfg_valid,
	input  logic                                cfg_index,
	input  logic [pcss_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  pcss_pkg::cmd_t                      cmd,
	output pcss_pkg::sts_t                      sts
);

	logic [pcss_pkg::ACT_W-1:0]   active_q;
	logic [pcss_pkg::MINP_W-1:0]  minp_q;
	pcss_pkg::period_t            period_q [pcss_pkg::MAX_CHANNELS];
	pcss_pkg::period_t            cd_q     [pcss_pkg::MAX_CHANNELS];
	logic [pcss_pkg::MAX_CHANNELS-1:0] pend_q;
	logic                         busy_q;
	logic [pcss_pkg::CH_W-1:0]    last_q;
	logic [pcss_pkg::CNT_W-1:0]   idx_q;
	logic [pcss_pkg::CNT_W-1:0]   ptr_q;
	pcss_pkg::req_t               item_q;
	logic                         gv_q;
	logic [pcss_pkg::CHAN_FIELD_W-1:0] gch_q;
	logic                         st_q;
	pcss_pkg::rsp_t               rsp_q;
	logic                         rsp_valid_q;

	logic [pcss_pkg::CNT_W-1:0]   n_w;
	logic [pcss_pkg::CH_W-1:0]    rd_i;
	logic [pcss_pkg::CH_W-1:0]    ptr_i;
	pcss_pkg::period_t            rd_period;
	pcss_pkg::period_t            rd_cd;
	pcss_pkg::period_t            set_p;
	logic                         ch_bad;
	logic                         upd_hit;
	logic [pcss_pkg::CNT_W-1:0]   ptr_nx;
	logic                         scan_hit;

	assign n_w = (32'(active_q) > 32'(pcss_pkg::MAX_CHANNELS))
		? pcss_pkg::CNT_W'(pcss_pkg::MAX_CHANNELS) : pcss_pkg::CNT_W'(active_q);
	assign rd_i      = cmd.tick_step ? idx_q[pcss_pkg::CH_W-1:0]
		: pcss_pkg::CH_W'(item_q.channel);
	assign rd_period = period_q[rd_i];
	assign rd_cd     = cd_q[rd_i];
	assign set_p     = pcss_pkg::sat_period(item_q.period_ms);
	assign ch_bad    = 32'(item_q.channel) >= 32'(n_w);
	assign upd_hit   = !ch_bad && (rd_period == pcss_pkg::PERIOD_BITS'(1));
	assign ptr_i     = ptr_q[pcss_pkg::CH_W-1:0];
	assign ptr_nx    = ptr_q + pcss_pkg::CNT_W'(1);
	assign scan_hit  = pend_q[ptr_i];

	always_comb begin
		sts.kind     = item_q.kind;
		sts.upd_hit  = upd_hit;
		sts.n_zero   = (n_w == '0);
		sts.idx_last = ((idx_q + pcss_pkg::CNT_W'(1)) == n_w);
		sts.ptr_ge_n = (ptr_q >= n_w);
		sts.no_scan  = busy_q || (n_w == '0);
		sts.scan_hit = scan_hit;
		sts.out_free = !rsp_valid_q || !rsp_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= pcss_pkg::ACTIVE_RESET;
			minp_q   <= pcss_pkg::MINP_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				pcss_pkg::CFG_ACTIVE_CHANNELS: active_q <= cfg_data[pcss_pkg::ACT_W-1:0];
				pcss_pkg::CFG_MIN_PERIOD:      minp_q   <= cfg_data[pcss_pkg::MINP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pcss_pkg::MAX_CHANNELS; i++) begin
				period_q[i] <= '0;
				cd_q[i]     <= pcss_pkg::PERIOD_BITS'(1);
			end
			pend_q <= '0;
			busy_q <= 1'b0;
			last_q <= '0;
			idx_q  <= '0;
			ptr_q  <= '0;
		end else begin
			if (cmd.load_item) begin
				idx_q <= '0;
				ptr_q <= pcss_pkg::CNT_W'(last_q) + pcss_pkg::CNT_W'(1);
			end
			if (cmd.exec) begin
				unique case (item_q.kind)
					pcss_pkg::KIND_UPDATE: begin
						if (upd_hit) begin
							pend_q[rd_i] <= 1'b1;
						end
					end
					pcss_pkg::KIND_SET_PERIOD: begin
						if (!ch_bad) begin
							if (set_p == '0) begin
								period_q[rd_i] <= '0;
								cd_q[rd_i]     <= pcss_pkg::PERIOD_BITS'(1);
							end else if (set_p < pcss_pkg::PERIOD_BITS'(minp_q)) begin
								period_q[rd_i] <= pcss_pkg::PERIOD_BITS'(1);
								cd_q[rd_i]     <= pcss_pkg::PERIOD_BITS'(1);
							end else begin
								period_q[rd_i] <= set_p;
								cd_q[rd_i]     <= set_p;
							end
						end
					end
					pcss_pkg::KIND_STOP_ALL: begin
						for (int i = 0; i < pcss_pkg::MAX_CHANNELS; i++) begin
							period_q[i] <= '0;
						end
						pend_q <= '0;
					end
					pcss_pkg::KIND_WRITE_DONE: busy_q <= 1'b0;
					default: ;
				endcase
			end
			if (cmd.tick_step) begin
				if (rd_period > pcss_pkg::PERIOD_BITS'(1) && rd_cd != '0) begin
					if (rd_cd == pcss_pkg::PERIOD_BITS'(1)) begin
						pend_q[rd_i] <= 1'b1;
						cd_q[rd_i]   <= rd_period;
					end else begin
						cd_q[rd_i] <= rd_cd - pcss_pkg::PERIOD_BITS'(1);
					end
				end
				idx_q <= idx_q + pcss_pkg::CNT_W'(1);
			end
			if (cmd.mod_step) begin
				ptr_q <= ptr_q - n_w;
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end
			if (cmd.scan_step) begin
				if (scan_hit) begin
					pend_q[ptr_i] <= 1'b0;
					busy_q        <= 1'b1;
					last_q        <= ptr_i;
				end else begin
					ptr_q <= (ptr_nx == n_w) ? '0 : ptr_nx;
					idx_q <= idx_q + pcss_pkg::CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= req;
			gv_q   <= 1'b0;
			gch_q  <= '0;
			st_q   <= 1'b0;
		end
		if (cmd.exec && ch_bad && (item_q.kind == pcss_pkg::KIND_UPDATE
			|| item_q.kind == pcss_pkg::KIND_SET_PERIOD)) begin
			st_q <= 1'b1;
		end
		if (cmd.scan_step && scan_hit) begin
			gv_q  <= 1'b1;
			gch_q <= pcss_pkg::CHAN_FIELD_W'(ptr_i);
		end
		if (cmd.load_out) begin
			rsp_q.grant_valid   <= gv_q;
			rsp_q.grant_channel <= gch_q;
			rsp_q.status        <= st_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule

>>> sim/send_grant_monitor.sv
// Channel monitor for the send scheduler: predicts each grant response and compares it.
`timescale 1ns / 1ps

module send_grant_monitor (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	input  logic                            req_stall,
	input  pcss_pkg::req_t                  req,
	input  logic                            rsp_valid,
	input  logic                            rsp_stall,
	input  pcss_pkg::rsp_t                  rsp,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic                            cfg_index,
	input  logic [pcss_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              errors,
	output int                              open_cnt
);
	import pcss_pkg::*;

	period_t                 per_tab [MAX_CHANNELS];
	period_t                 cnt_tab [MAX_CHANNELS];
	logic                    pend [MAX_CHANNELS];
	logic                    busy;
	logic [CHAN_FIELD_W-1:0] last_ch;
	logic [ACT_W-1:0]        act_cfg;
	logic [MINP_W-1:0]       minp_cfg;
	rsp_t                    grants_due [$];

	function automatic int live_count();
		return (int'(act_cfg) > MAX_CHANNELS) ? MAX_CHANNELS : int'(act_cfg);
	endfunction

	function automatic logic pick_next(output logic [CHAN_FIELD_W-1:0] ch);
		int n;
		int i;
		int c;
		n = live_count();
		ch = '0;
		if (busy || n == 0) begin
			return 1'b0;
		end
		for (i = 0; i < n; i++) begin
			c = (int'(last_ch) + 1 + i) % n;
			if (pend[c]) begin
				pend[c] = 1'b0;
				busy = 1'b1;
				last_ch = CHAN_FIELD_W'(c);
				ch = CHAN_FIELD_W'(c);
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic rsp_t predict_grant(input req_t r);
		rsp_t                    o;
		int                      n;
		int                      i;
		period_t                 p;
		logic [CHAN_FIELD_W-1:0] ch;
		o = '0;
		ch = '0;
		n = live_count();
		case (r.kind)
			KIND_TICK: begin
				for (i = 0; i < n; i++) begin
					if (per_tab[i] > 1 && cnt_tab[i] != '0) begin
						cnt_tab[i] = cnt_tab[i] - 1'b1;
						if (cnt_tab[i] == '0) begin
							pend[i] = 1'b1;
							cnt_tab[i] = per_tab[i];
						end
					end
				end
				o.grant_valid = pick_next(ch);
			end
			KIND_UPDATE: begin
				if (int'(r.channel) >= n) begin
					o.status = 1'b1;
				end else if (per_tab[r.channel] == 1) begin
					pend[r.channel] = 1'b1;
					o.grant_valid = pick_next(ch);
				end
			end
			KIND_SET_PERIOD: begin
				if (int'(r.channel) >= n) begin
					o.status = 1'b1;
				end else begin
					p = (32'(r.period_ms) > 32'(PERIOD_MAX)) ? PERIOD_MAX
						: PERIOD_BITS'(r.period_ms);
					if (p == '0) begin
						per_tab[r.channel] = '0;
						cnt_tab[r.channel] = PERIOD_BITS'(1);
					end else if (p < minp_cfg) begin
						per_tab[r.channel] = PERIOD_BITS'(1);
						cnt_tab[r.channel] = PERIOD_BITS'(1);
					end else begin
						per_tab[r.channel] = p;
						cnt_tab[r.channel] = p;
					end
				end
			end
			KIND_STOP_ALL: begin
				for (i = 0; i < MAX_CHANNELS; i++) begin
					per_tab[i] = '0;
					pend[i] = 1'b0;
				end
			end
			KIND_WRITE_DONE: begin
				busy = 1'b0;
			end
			default: begin
			end
		endcase
		o.grant_channel = o.grant_valid ? ch : '0;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		int   i;
		if (!arst_n) begin
			for (i = 0; i < MAX_CHANNELS; i++) begin
				per_tab[i] = '0;
				cnt_tab[i] = PERIOD_BITS'(1);
				pend[i] = 1'b0;
			end
			busy = 1'b0;
			last_ch = '0;
			act_cfg = ACTIVE_RESET;
			minp_cfg = MINP_RESET;
			grants_due.delete();
			errors <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_ACTIVE_CHANNELS) begin
					act_cfg = ACT_W'(cfg_data);
				end else begin
					minp_cfg = MINP_W'(cfg_data);
				end
			end
			if (req_valid && !req_stall) begin
				grants_due.push_back(predict_grant(req));
			end
			if (rsp_valid && !rsp_stall) begin
				if (grants_due.size() == 0) begin
					$display("%0t: unexpected transfer gv=%0d ch=%0d st=%0d", $time,
						rsp.grant_valid, rsp.grant_channel, rsp.status);
					errors <= errors + 1;
				end else begin
					want = grants_due.pop_front();
					if (want.grant_valid !== rsp.grant_valid
						|| want.grant_channel !== rsp.grant_channel
						|| want.status !== rsp.status) begin
						$display("%0t: expected gv=%0d ch=%0d st=%0d, actual gv=%0d ch=%0d st=%0d",
							$time, want.grant_valid, want.grant_channel, want.status,
							rsp.grant_valid, rsp.grant_channel, rsp.status);
						errors <= errors + 1;
					end
				end
			end
		end
		open_cnt <= grants_due.size();
	end

endmodule

>>> sim/periodic_channel_send_scheduler_unit_tb.sv
// Testbench top for the send scheduler: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps

module periodic_channel_send_scheduler_unit_tb;
	import pcss_pkg::*;

	localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
	localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;
	localparam int                WATCHDOG_LIMIT   = 2000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_stall;
	req_t                  req = '0;
	logic                  rsp_valid;
	logic                  rsp_stall = 1'b0;
	rsp_t                  rsp;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic                  cfg_index = CFG_ACTIVE_CHANNELS;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int                    errors;
	int                    open_cnt;
	logic                  idle_on = 1'b1;
	int                    act_now = 16;
	int                    minp_now = 10;
	int                    stall_left = 0;
	int                    quiet_cycles = 0;

	always #5 clk = ~clk;

	periodic_channel_send_scheduler_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	send_grant_monitor monitor (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.open_cnt  (open_cnt)
	);

	always @(negedge clk) begin
		if (stall_left > 0) begin
			rsp_stall = 1'b1;
			stall_left = stall_left - 1;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			rsp_stall = 1'b1;
			stall_left = $urandom_range(0, 10);
		end else begin
			rsp_stall = 1'b0;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
			|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic push_cmd(input logic [KIND_W-1:0] k, input logic [CHAN_FIELD_W-1:0] ch,
		input logic [REQ_PERIOD_W-1:0] per);
		int gap;
		@(negedge clk);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			req_valid = 1'b0;
			gap = $urandom_range(1, 11);
			repeat (gap) @(negedge clk);
		end
		req_valid = 1'b1;
		req = '{kind: k, channel: ch, period_ms: per};
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	task automatic settle();
		@(negedge clk);
		req_valid = 1'b0;
		@(posedge clk);
		while (open_cnt != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_config(input logic [CFG_DATA_W-1:0] act, input logic [CFG_DATA_W-1:0] minp);
		write_reg(CFG_ACTIVE_CHANNELS, act);
		write_reg(CFG_MIN_PERIOD, minp);
		act_now = int'(act[ACT_W-1:0]);
		minp_now = int'(minp);
	endtask

	function automatic logic [CHAN_FIELD_W-1:0] pick_chan();
		int n;
		n = (act_now > MAX_CHANNELS) ? MAX_CHANNELS : act_now;
		if (n > 0 && $urandom_range(0, 6) != 0) begin
			return CHAN_FIELD_W'($urandom_range(0, n - 1));
		end
		return CHAN_FIELD_W'($urandom_range(0, 15));
	endfunction

	function automatic logic [REQ_PERIOD_W-1:0] pick_period();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0) begin
			return '0;
		end else if (roll == 1) begin
			return REQ_PERIOD_W'($urandom_range(0, 65535));
		end
		return REQ_PERIOD_W'($urandom_range(1, 2 * minp_now + 6));
	endfunction

	task automatic run_mix(input int count, input logic allow_idle);
		int                      i;
		int                      roll;
		logic [KIND_W-1:0]       k;
		idle_on = allow_idle;
		repeat (4) push_cmd(KIND_SET_PERIOD, pick_chan(), pick_period());
		for (i = 0; i < count; i++) begin
			if (allow_idle && i % 40 == 0) begin
				idle_on = $urandom_range(0, 3) != 0;
			end
			roll = $urandom_range(0, 99);
			if (roll < 38) begin
				k = KIND_TICK;
			end else if (roll < 58) begin
				k = KIND_WRITE_DONE;
			end else if (roll < 76) begin
				k = KIND_UPDATE;
			end else if (roll < 93) begin
				k = KIND_SET_PERIOD;
			end else if (roll < 96) begin
				k = KIND_STOP_ALL;
			end else if (roll < 98) begin
				k = KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
			end else begin
				k = KIND_TICK;
			end
			push_cmd(k, pick_chan(), pick_period());
		end
		settle();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		set_config(8'd16, 8'd4);
		push_cmd(KIND_TICK, 4'd0, 16'd0);
		push_cmd(KIND_SET_PERIOD, 4'd0, 16'd0);
		push_cmd(KIND_SET_PERIOD, 4'd1, 16'hFFFF);
		push_cmd(KIND_SET_PERIOD, 4'd2, 16'd2);
		push_cmd(KIND_SET_PERIOD, 4'd3, 16'd4);
		push_cmd(KIND_UPDATE, 4'd2, 16'd0);
		push_cmd(KIND_UPDATE, 4'd3, 16'd0);
		push_cmd(KIND_UPDATE, 4'd2, 16'd0);
		push_cmd(KIND_WRITE_DONE, 4'd0, 16'd0);
		push_cmd(KIND_TICK, 4'd0, 16'd0);
		push_cmd(KIND_WRITE_DONE, 4'd0, 16'd0);
		repeat (3) push_cmd(KIND_TICK, 4'd0, 16'd0);
		push_cmd(KIND_WRITE_DONE, 4'd0, 16'd0);
		push_cmd(KIND_SET_PERIOD, 4'd15, 16'h5555);
		push_cmd(KIND_SET_PERIOD, 4'd15, 16'd1);
		push_cmd(KIND_UPDATE, 4'd15, 16'd0);
		push_cmd(KIND_WRITE_DONE, 4'd0, 16'd0);
		push_cmd(KIND_STOP_ALL, 4'd0, 16'd0);
		push_cmd(KIND_UPDATE, 4'd2, 16'd0);
		push_cmd(KIND_SPARE_FIRST, 4'd1, 16'hAAAA);
		push_cmd(KIND_SPARE_FIRST + 3'd1, 4'd2, 16'd0);
		push_cmd(KIND_SPARE_LAST, 4'd3, 16'd0);
		settle();

		set_config(8'd4, 8'd1);
		push_cmd(KIND_SET_PERIOD, 4'd9, 16'd3);
		push_cmd(KIND_UPDATE, 4'd15, 16'd0);
		push_cmd(KIND_SET_PERIOD, 4'd0, 16'd1);
		push_cmd(KIND_UPDATE, 4'd0, 16'd0);
		push_cmd(KIND_WRITE_DONE, 4'd0, 16'd0);
		settle();

		set_config(8'd16, 8'd4);
		run_mix(100, 1'b1);
		set_config(8'd3, 8'd1);
		run_mix(80, 1'b1);
		set_config(CFG_DATA_W'($urandom_range(1, 16)), CFG_DATA_W'($urandom_range(2, 20)));
		run_mix(80, 1'b1);
		set_config(8'hE0, 8'd255);
		run_mix(30, 1'b1);
		set_config(8'd31, 8'd7);
		run_mix(80, 1'b1);
		set_config(8'd1, 8'd2);
		run_mix(40, 1'b1);
		set_config(8'd16, 8'd10);
		run_mix(100, 1'b0);

		repeat (60) @(posedge clk);
		if (errors == 0 && open_cnt == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/pcss_pkg.sv
hw/rtl/pcss_ctrl.sv
hw/rtl/pcss_dp.sv
hw/rtl/periodic_channel_send_scheduler_unit.sv
sim/send_grant_monitor.sv
sim/periodic_channel_send_scheduler_unit_tb.sv
